// File: rtl/mlwf_pkg.sv
// Shared constants, types and saturation helpers for the ladder filter wah.
`default_nettype none
package mlwf_pkg;

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int CH_W      = 3;
  localparam int COEF_W    = 24;
  localparam int GAIN_W    = 40;
  localparam int ST_W      = 40;
  localparam int RES_W     = 48;
  localparam int CFG_IDX_W = 2;

  // Digit-serial multiplier geometry
  localparam int DIGIT_W     = 8;
  localparam int COEF_DIGITS = COEF_W / DIGIT_W;
  localparam int GAIN_DIGITS = GAIN_W / DIGIT_W;
  localparam int LOW_W       = GAIN_DIGITS * DIGIT_W;
  localparam int CNT_W       = 3;
  localparam int Q_SH        = 20;
  localparam int G_SH        = 32;

  // Channel state store
  localparam int CHANNELS  = 8;
  localparam int STAGES    = 5;
  localparam int STG_W     = 3;
  localparam int CHAN_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * STAGES;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Stage slots within one channel's row
  localparam logic [STG_W-1:0] STG_FIRST  = 3'd0;
  localparam logic [STG_W-1:0] STG_SECOND = 3'd1;
  localparam logic [STG_W-1:0] STG_THIRD  = 3'd2;
  localparam logic [STG_W-1:0] STG_FOURTH = 3'd3;
  localparam logic [STG_W-1:0] STG_OUTPUT = 3'd4;

  // Sequencer operations, one multiply each
  localparam logic [2:0] OP_FIRST    = 3'd0;
  localparam logic [2:0] OP_FEEDBACK = 3'd1;
  localparam logic [2:0] OP_SECOND   = 3'd2;
  localparam logic [2:0] OP_THIRD    = 3'd3;
  localparam logic [2:0] OP_FOURTH   = 3'd4;
  localparam logic [2:0] OP_GAIN     = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLE_COEF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_GAIN = 2'd1;

  // Constants
  localparam logic signed [COEF_W-1:0] FB_COEF    = 24'sd3355443;
  localparam logic signed [COEF_W-1:0] POLE_RESET = 24'sd1018669;
  localparam logic [GAIN_W-1:0]        GAIN_RESET = 40'd2830;

  typedef struct packed {
    logic load;
    logic step;
    logic gain_mode;
  } mul_ctrl_t;

  typedef struct packed {
    logic last;
    logic gain_mode;
  } mul_stat_t;

  typedef struct packed {
    logic               rd_en;
    logic [STG_W-1:0]   rd_stage;
    logic               wr_en;
    logic [STG_W-1:0]   wr_stage;
    logic [ST_W-1:0]    wr_data;
    logic               mark_en;
    logic [CHAN_AW-1:0] ch;
  } ram_req_t;

  // Clamp a wide result to the signed state range.
  function automatic logic signed [ST_W-1:0] sat_state(input logic signed [RES_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if ((&v[RES_W-1:ST_W-1]) || !(|v[RES_W-1:ST_W-1])) begin
      r = v[ST_W-1:0];
    end else if (v[RES_W-1]) begin
      r = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ST_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Clamp four times the output stage to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ST_W+1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if ((&v[ST_W+1:SAMPLE_W-1]) || !(|v[ST_W+1:SAMPLE_W-1])) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[ST_W+1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Storage slot of the state word that an operation multiplies or writes.
  function automatic logic [STG_W-1:0] op_stage(input logic [2:0] op);
    logic [STG_W-1:0] s;
    case (op)
      OP_FIRST:    s = STG_FIRST;
      OP_FEEDBACK: s = STG_OUTPUT;
      OP_SECOND:   s = STG_SECOND;
      OP_THIRD:    s = STG_THIRD;
      OP_FOURTH:   s = STG_FOURTH;
      OP_GAIN:     s = STG_OUTPUT;
      default:     s = STG_FIRST;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/moog_ladder_wah_filter.sv
// Top level of the multichannel fourth-order ladder filter wah.
//
// Input channel in_*: one request carries sample_in (in_tdata, signed Q1.23) and
// channel_num (in_tuser). Each request runs one filter update for that channel.
// Result channel out_*: sample_out (out_tdata) and out_channel (out_tuser).
// Configuration channel cfg_*: index 0 writes pole_coef, index 1 stage_gain;
// other indexes are dropped. Write only while no request is in flight.
//
// Timing: the block works on one request at a time. Six multiplies run on a
// shared digit-serial multiplier that consumes one coefficient byte per cycle
// (24-bit Q4.20 pole or feedback coefficient, 40-bit stage gain), with a state
// memory read ahead of each product but the gain one and an accumulate step after each.
// The result reaches out_tvalid through the output register, and a new request
// is taken only once the previous result has been handed to that register.
// A stalled receiver holds the result in the output register; the next input
// request is still taken and runs until its own result must be handed over.
//
// Reset (rst_n low, synchronous) clears all channel state to zero through one
// valid bit per channel, restores the register defaults and empties the output.
`default_nettype none
module moog_ladder_wah_filter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mlwf_pkg::SAMPLE_W-1:0]    in_tdata,   // [23:0] sample_in
  input  wire logic [mlwf_pkg::CH_W-1:0]        in_tuser,   // [2:0] channel_num
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [mlwf_pkg::SAMPLE_W-1:0]         out_tdata,  // [23:0] sample_out
  output logic [mlwf_pkg::CH_W-1:0]             out_tuser,  // [2:0] out_channel
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mlwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mlwf_pkg::GAIN_W-1:0]      cfg_data
);
  import mlwf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]                  op_r, op_nxt;
  logic [CH_W-1:0]             ch_r, ch_nxt;
  logic signed [SAMPLE_W-1:0]  x_r, x_nxt;
  logic signed [RES_W-1:0]     sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0]  y_r, y_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]         out_data_r, out_data_nxt;
  logic [CH_W-1:0]             out_ch_r, out_ch_nxt;
  logic signed [COEF_W-1:0]    pole_r;
  logic [GAIN_W-1:0]           gain_r;

  mul_ctrl_t               mul_ctrl;
  mul_stat_t               mul_stat;
  logic [GAIN_W-1:0]       mul_coef;
  logic signed [ST_W-1:0]  mul_mcand;
  logic signed [RES_W-1:0] mul_prod;
  ram_req_t                ram_req;
  logic signed [ST_W-1:0]  ram_rdata;

  logic                    in_fire;
  logic                    ch_ok;
  logic signed [RES_W-1:0] acc_sum;
  logic signed [ST_W-1:0]  stage_val;
  logic                    out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign ch_ok     = (32'(in_tuser) < 32'(CHANNELS));
  assign out_free  = !out_valid_r || out_tready;

  // Feedback step subtracts, the stage steps add onto the running value.
  assign acc_sum   = (op_r == OP_FEEDBACK) ? (sum_r - mul_prod) : (sum_r + mul_prod);
  assign stage_val = sat_state((op_r == OP_GAIN) ? mul_prod : acc_sum);

  // The gain product multiplies the fresh fourth stage held in the accumulator.
  assign mul_mcand = (op_r == OP_GAIN) ? sum_r[ST_W-1:0] : ram_rdata;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    x_nxt         = x_r;
    sum_nxt       = sum_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_ch_nxt    = out_ch_r;

    mul_ctrl      = '0;
    mul_coef      = '0;

    ram_req          = '0;
    ram_req.ch       = CHAN_AW'(ch_r);
    ram_req.rd_stage = op_stage(op_r);
    // The feedback step completes the first stage, so its sum lands in the first slot.
    ram_req.wr_stage = (op_r == OP_FEEDBACK) ? STG_FIRST : op_stage(op_r);
    ram_req.wr_data  = stage_val;

    // Drop the result once the receiver takes it.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ch_nxt = in_tuser;
          x_nxt  = in_tdata;
          op_nxt = OP_FIRST;
          if (ch_ok) begin
            state_nxt = S_READ;
          end else begin
            y_nxt     = '0;
            state_nxt = S_OUT;
          end
        end
      end
      S_READ: begin
        ram_req.rd_en = 1'b1;
        mul_ctrl.load = 1'b1;
        mul_coef      = GAIN_W'($unsigned((op_r == OP_FEEDBACK) ? FB_COEF : pole_r));
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        mul_ctrl.step = 1'b1;
        if (mul_stat.last) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        case (op_r)
          OP_FIRST: begin
            sum_nxt   = RES_W'(x_r) + mul_prod;
            op_nxt    = OP_FEEDBACK;
            state_nxt = S_READ;
          end
          OP_FEEDBACK, OP_SECOND, OP_THIRD: begin
            ram_req.wr_en = 1'b1;
            sum_nxt       = RES_W'(stage_val);
            op_nxt        = op_r + 3'd1;
            state_nxt     = S_READ;
          end
          OP_FOURTH: begin
            ram_req.wr_en      = 1'b1;
            sum_nxt            = RES_W'(stage_val);
            op_nxt             = OP_GAIN;
            mul_ctrl.load      = 1'b1;
            mul_ctrl.gain_mode = 1'b1;
            mul_coef           = gain_r;
            state_nxt          = S_MUL;
          end
          OP_GAIN: begin
            ram_req.wr_en   = 1'b1;
            ram_req.mark_en = 1'b1;
            y_nxt           = sat_sample({stage_val, 2'b00});
            state_nxt       = S_OUT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_OUT: begin
        // Hold here until the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = y_r;
          out_ch_nxt    = ch_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    x_r        <= x_nxt;
    sum_r      <= sum_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
    out_ch_r   <= out_ch_nxt;
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_r <= POLE_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLE_COEF:  pole_r <= cfg_data[COEF_W-1:0];
        REG_STAGE_GAIN: gain_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mlwf_digit_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mul_ctrl),
    .coef_in (mul_coef),
    .mcand   (mul_mcand),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  mlwf_state_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ch_r;

endmodule
`default_nettype wire

// File: rtl/mlwf_digit_mul.sv
// Digit-serial signed multiplier: one coefficient byte per cycle while stepped, rounded result.
`default_nettype none
module mlwf_digit_mul (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire mlwf_pkg::mul_ctrl_t              ctrl,
  input  wire logic [mlwf_pkg::GAIN_W-1:0]      coef_in,
  input  wire logic signed [mlwf_pkg::ST_W-1:0] mcand,
  output mlwf_pkg::mul_stat_t                   stat,
  output logic signed [mlwf_pkg::RES_W-1:0]     product
);
  import mlwf_pkg::*;

  localparam int PP_W   = ST_W + DIGIT_W + 1;
  localparam int Q_BASE = LOW_W - COEF_DIGITS * DIGIT_W;
  localparam int Q_RB   = Q_BASE + Q_SH - 1;
  localparam int QX     = LOW_W - Q_RB - 1;
  localparam int G_BASE = LOW_W - GAIN_DIGITS * DIGIT_W;
  localparam int G_RB   = G_BASE + G_SH - 1;

  logic signed [ST_W-1:0] acc_r, acc_nxt;
  logic [LOW_W-1:0]       low_r, low_nxt;
  logic [GAIN_W-1:0]      coef_r, coef_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   gain_r, gain_nxt;

  logic                    last;
  logic signed [DIGIT_W:0] digit;
  logic signed [PP_W-1:0]  pp;
  logic signed [PP_W-1:0]  sum;
  logic signed [RES_W-1:0] prod_q;
  logic signed [RES_W-1:0] prod_g;

  assign last = gain_r ? (cnt_r == CNT_W'(GAIN_DIGITS - 1))
                       : (cnt_r == CNT_W'(COEF_DIGITS - 1));

  // Top digit of a signed coefficient carries the sign.
  assign digit = {(last && !gain_r) ? coef_r[DIGIT_W-1] : 1'b0, coef_r[DIGIT_W-1:0]};
  assign pp    = mcand * digit;
  assign sum   = PP_W'(acc_r) + pp;

  always_comb begin
    acc_nxt  = acc_r;
    low_nxt  = low_r;
    coef_nxt = coef_r;
    cnt_nxt  = cnt_r;
    gain_nxt = gain_r;
    if (ctrl.load) begin
      acc_nxt  = '0;
      coef_nxt = coef_in;
      cnt_nxt  = '0;
      gain_nxt = ctrl.gain_mode;
    end else if (ctrl.step) begin
      acc_nxt  = sum[ST_W+DIGIT_W-1:DIGIT_W];
      low_nxt  = {sum[DIGIT_W-1:0], low_r[LOW_W-1:DIGIT_W]};
      coef_nxt = coef_r >> DIGIT_W;
      cnt_nxt  = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      gain_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      gain_r <= gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    low_r  <= low_nxt;
    coef_r <= coef_nxt;
  end

  // Round half up: floor shift plus the bit just below the cut.
  assign prod_q = {{(RES_W-ST_W-QX){acc_r[ST_W-1]}}, acc_r, low_r[LOW_W-1:Q_RB+1]}
                  + RES_W'(low_r[Q_RB]);
  assign prod_g = {acc_r, low_r[LOW_W-1:G_RB+1]} + RES_W'(low_r[G_RB]);

  assign product        = gain_r ? prod_g : prod_q;
  assign stat.last      = last;
  assign stat.gain_mode = gain_r;

endmodule
`default_nettype wire

// File: rtl/mlwf_state_ram.sv
// Per-channel stage state memory with a valid bit for each channel row.
`default_nettype none
module mlwf_state_ram (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mlwf_pkg::ram_req_t                req,
  output logic signed [mlwf_pkg::ST_W-1:0]       rdata
);
  import mlwf_pkg::*;

  logic [ST_W-1:0]     mem [MEM_DEPTH];
  logic [CHANNELS-1:0] valid_r;
  logic [ST_W-1:0]     rdata_r;
  logic                rvalid_r;
  logic [MEM_AW-1:0]   rd_addr;
  logic [MEM_AW-1:0]   wr_addr;

  assign rd_addr = MEM_AW'(req.ch) * MEM_AW'(STAGES) + MEM_AW'(req.rd_stage);
  assign wr_addr = MEM_AW'(req.ch) * MEM_AW'(STAGES) + MEM_AW'(req.wr_stage);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.mark_en) begin
        valid_r[req.ch] <= 1'b1;
      end
      if (req.rd_en) begin
        rvalid_r <= valid_r[req.ch];
      end
    end
  end

  // A row never written since reset reads as zero.
  assign rdata = rvalid_r ? rdata_r : '0;

endmodule
`default_nettype wire
